// ===== design/hall_encoder_rotor_angle_tracker_top_macros.svh =====
// assertion macros for the hall and encoder rotor angle tracker
`ifndef HALL_ENCODER_ROTOR_ANGLE_TRACKER_TOP_MACROS_SVH
`define HALL_ENCODER_ROTOR_ANGLE_TRACKER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define HERT_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HERT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define HERT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hert_pkg.sv =====
// shared constants, codes and sector tables of the rotor angle tracker
`default_nettype none
package hert_pkg;

  localparam int ANGLE_W      = 32;
  localparam int SPEED_W      = 48;
  localparam int SECT_ANGLE_W = 19;
  localparam int STEP_W       = 16;
  localparam int COUNT_W      = 13;
  localparam int TRANS_W      = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 19;
  localparam int NUM_SECTORS  = 6;

  localparam int DEF_ENCODER_LINES = 5000;

  // speed divide: magnitude shifted up by 24 plus half divisor, over the divisor
  localparam int SPEED_DIV_VAL = 95493;
  localparam int DIV_W         = 17;
  localparam int SPEED_SHIFT   = 24;
  localparam logic [DIV_W-1:0] SPEED_DIVISOR = DIV_W'(SPEED_DIV_VAL);

  // reciprocal of the divisor scaled by 2^56, split in two halves
  localparam int RECIP_SHIFT = ANGLE_W + SPEED_SHIFT;
  localparam int RECIP_SPLIT = 20;
  localparam int RECIP_W     = 2 * RECIP_SPLIT;
  localparam logic [RECIP_W-1:0] SPEED_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SPEED_DIV_VAL));
  localparam logic [RECIP_SPLIT-1:0] RECIP_LO = SPEED_RECIP[RECIP_SPLIT-1:0];
  localparam logic [RECIP_SPLIT-1:0] RECIP_HI = SPEED_RECIP[RECIP_W-1:RECIP_SPLIT];

  // shared multiplier and remainder widths
  localparam int MUL_A_W = ANGLE_W;
  localparam int MUL_B_W = RECIP_SPLIT;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = ANGLE_W + RECIP_W;
  localparam int REM_W   = RECIP_SPLIT;
  localparam logic [REM_W-1:0] REM_BIAS    = REM_W'(SPEED_DIV_VAL / 2);
  localparam logic [REM_W-1:0] REM_ONE_DIV = REM_W'(SPEED_DIV_VAL);
  localparam logic [REM_W-1:0] REM_TWO_DIV = REM_W'(2 * SPEED_DIV_VAL);
  localparam logic [REM_W-1:0] REM_LIMIT   = REM_W'(3 * SPEED_DIV_VAL);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SIX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_FOUR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_FIVE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE   = 3'd6;

  localparam logic [SECT_ANGLE_W-1:0] SECTOR_RESET [NUM_SECTORS] = '{
    19'd22387, 19'd95840, 19'd161369, 19'd237385, 19'd300352, 19'd362702
  };
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd412;

  // transition codes
  localparam logic [TRANS_W-1:0] TR_NONE    = 2'd0;
  localparam logic [TRANS_W-1:0] TR_FWD     = 2'd1;
  localparam logic [TRANS_W-1:0] TR_BWD     = 2'd2;
  localparam logic [TRANS_W-1:0] TR_INVALID = 2'd3;

  // action codes
  localparam logic ACT_HALL    = 1'b0;
  localparam logic ACT_ENCODER = 1'b1;

  typedef logic [2:0] sector_t;

  function automatic logic sector_ok(input sector_t s);
    return (s != 3'd0) && (s != 3'd7);
  endfunction

  function automatic logic [CFG_IDX_W-1:0] sector_reg_idx(input sector_t s);
    logic [CFG_IDX_W-1:0] idx;
    case (s)
      3'd1:    idx = REG_SECTOR_ONE;
      3'd2:    idx = REG_SECTOR_TWO;
      3'd3:    idx = REG_SECTOR_THREE;
      3'd4:    idx = REG_SECTOR_FOUR;
      3'd5:    idx = REG_SECTOR_FIVE;
      default: idx = REG_SECTOR_SIX;
    endcase
    return idx;
  endfunction

  // forward order 6-4-5-1-3-2
  function automatic sector_t fwd_next(input sector_t s);
    sector_t n;
    case (s)
      3'd1:    n = 3'd3;
      3'd2:    n = 3'd6;
      3'd3:    n = 3'd2;
      3'd4:    n = 3'd5;
      3'd5:    n = 3'd1;
      3'd6:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== design/hall_encoder_rotor_angle_tracker_top.sv =====
// rotor angle tracker from hall lines and encoder count, top level
// usage:
// - input channel (in_valid/in_ready) takes one word per item: a hall edge
//   (in_action low) or an encoder sample (in_action high)
// - result channel (out_valid/out_ready) gives one word per item: angle,
//   held speed and transition code
// - cfg channel writes the six sector entry angles and the encoder step
//   angle; cfg_ready always high, so the user writes only while the block is idle
// - hall item: the sector is stored on acceptance and the result word is
//   registered in S_EMIT; the next word is taken only after that
// - encoder item: one multiply, one add, one subtract, one negate, then the
//   speed divide by reciprocal on one shared 32 x 20 bit multiplier (low
//   half, high half, remainder) and a final correction; the result word is
//   registered in S_EMIT and the next word is taken only after that
// - in_ready is high only while no item is being worked on
// - the output register holds a finished word while out_ready is low; the
//   next item is still accepted and waits for the register to free up
// - synchronous reset clears angle, speed, last sector and output valid,
//   and reloads the configuration registers with their defaults
`default_nettype none
`include "hall_encoder_rotor_angle_tracker_top_macros.svh"

module hall_encoder_rotor_angle_tracker_top
  import hert_pkg::*;
#(
  parameter int ENCODER_LINES = DEF_ENCODER_LINES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_action,
  input  wire logic                     in_hall_u,
  input  wire logic                     in_hall_v,
  input  wire logic                     in_hall_w,
  input  wire logic [COUNT_W-1:0]       in_encoder_count,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [ANGLE_W-1:0]     out_rotor_angle,
  output logic signed [SPEED_W-1:0]     out_rotor_speed,
  output logic [TRANS_W-1:0]            out_transition,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int HALF_LINES = ENCODER_LINES / 2;
  localparam int DELTA_W = ((HALF_LINES >= (1 << COUNT_W)) ?
                            $clog2(HALF_LINES + 1) : COUNT_W) + 1;
  localparam int PROD_W  = DELTA_W + STEP_W + 1;
  localparam int PRODX_W = (PROD_W > ANGLE_W) ? PROD_W : ANGLE_W;
  localparam logic signed [DELTA_W-1:0] HALF_VAL = DELTA_W'(HALF_LINES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_ABS  = 4'd3;
  localparam logic [3:0] S_MLO  = 4'd4;
  localparam logic [3:0] S_MHI  = 4'd5;
  localparam logic [3:0] S_REM  = 4'd6;
  localparam logic [3:0] S_FIX  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]                state_r, state_nxt;
  sector_t                   last_sector_r, last_sector_nxt;
  logic [ANGLE_W-1:0]        tracked_angle_r, tracked_angle_nxt;
  logic [ANGLE_W-1:0]        angle_at_last_r, angle_at_last_nxt;
  logic [SPEED_W-1:0]        held_speed_r, held_speed_nxt;
  logic [TRANS_W-1:0]        trans_r, trans_nxt;
  logic [ANGLE_W-1:0]        prod_r, prod_nxt;
  logic [ANGLE_W-1:0]        mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [SPEED_W-1:0]        quot_r, quot_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0]        out_angle_r, out_angle_nxt;
  logic [SPEED_W-1:0]        out_speed_r, out_speed_nxt;
  logic [TRANS_W-1:0]        out_trans_r, out_trans_nxt;

  logic [SECT_ANGLE_W-1:0]   sector_angle_r [NUM_SECTORS];
  logic [STEP_W-1:0]         step_angle_r;

  // hall decode
  sector_t                   cur_sector;
  logic                      both_ok, hall_fwd, hall_bwd, hall_rep;
  logic [CFG_IDX_W-1:0]      snap_idx;
  logic [SECT_ANGLE_W-1:0]   snap_angle;
  logic [TRANS_W-1:0]        hall_trans;

  // encoder path
  logic signed [DELTA_W-1:0] delta_s;
  logic signed [STEP_W:0]    step_s;
  logic signed [PROD_W-1:0]  prod_w;
  logic signed [PRODX_W-1:0] prod_ext;
  logic [ANGLE_W-1:0]        angle_diff;
  logic [ANGLE_W-1:0]        diff_abs;

  // shared multiplier of the speed divide
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_P_W-1:0]        mul_p;
  logic [RECIP_W-1:0]        quot_est;
  logic [1:0]                quot_fix;

  assign cur_sector = {in_hall_u, in_hall_w, in_hall_v};
  assign both_ok    = sector_ok(cur_sector) && sector_ok(last_sector_r);
  assign hall_rep   = both_ok && (cur_sector == last_sector_r);
  assign hall_fwd   = both_ok && !hall_rep && (fwd_next(last_sector_r) == cur_sector);
  assign hall_bwd   = both_ok && !hall_rep && (fwd_next(cur_sector) == last_sector_r);
  assign snap_idx   = hall_fwd ? sector_reg_idx(cur_sector) : sector_reg_idx(last_sector_r);
  assign snap_angle = sector_angle_r[snap_idx];

  always_comb begin
    if (hall_fwd) begin
      hall_trans = TR_FWD;
    end else if (hall_bwd) begin
      hall_trans = TR_BWD;
    end else if (hall_rep) begin
      hall_trans = TR_NONE;
    end else begin
      hall_trans = TR_INVALID;
    end
  end

  assign delta_s  = signed'(DELTA_W'(in_encoder_count)) - HALF_VAL;
  assign step_s   = signed'({1'b0, step_angle_r});
  assign prod_w   = PROD_W'(delta_s) * PROD_W'(step_s);
  assign prod_ext = PRODX_W'(prod_w);

  assign angle_diff = tracked_angle_r - angle_at_last_r;
  assign diff_abs   = ANGLE_W'(0) - mag_r;

  always_comb begin
    case (state_r)
      S_MHI: begin
        mul_a = mag_r;
        mul_b = RECIP_HI;
      end
      S_REM: begin
        mul_a = MUL_A_W'(quot_est[REM_W-1:0]);
        mul_b = MUL_B_W'(SPEED_DIVISOR);
      end
      default: begin
        mul_a = mag_r;
        mul_b = RECIP_LO;
      end
    endcase
  end

  assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign quot_est = acc_r[ACC_W-1 -: RECIP_W];

  // estimate is at most two below the rounded quotient
  always_comb begin
    if (rem_r >= REM_TWO_DIV) begin
      quot_fix = 2'd2;
    end else if (rem_r >= REM_ONE_DIV) begin
      quot_fix = 2'd1;
    end else begin
      quot_fix = 2'd0;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    last_sector_nxt   = last_sector_r;
    tracked_angle_nxt = tracked_angle_r;
    angle_at_last_nxt = angle_at_last_r;
    held_speed_nxt    = held_speed_r;
    trans_nxt         = trans_r;
    prod_nxt          = prod_r;
    mag_nxt           = mag_r;
    neg_nxt           = neg_r;
    acc_nxt           = acc_r;
    rem_nxt           = rem_r;
    quot_nxt          = quot_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_angle_nxt     = out_angle_r;
    out_speed_nxt     = out_speed_r;
    out_trans_nxt     = out_trans_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_HALL) begin
            last_sector_nxt = cur_sector;
            trans_nxt       = hall_trans;
            if (hall_fwd || hall_bwd) begin
              tracked_angle_nxt = ANGLE_W'(snap_angle);
            end
            state_nxt = S_EMIT;
          end else begin
            trans_nxt = TR_NONE;
            prod_nxt  = prod_ext[ANGLE_W-1:0];
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        tracked_angle_nxt = tracked_angle_r + prod_r;
        state_nxt         = S_DIFF;
      end
      S_DIFF: begin
        mag_nxt           = angle_diff;
        neg_nxt           = angle_diff[ANGLE_W-1];
        angle_at_last_nxt = tracked_angle_r;
        state_nxt         = S_ABS;
      end
      S_ABS: begin
        if (neg_r) begin
          mag_nxt = diff_abs;
        end
        state_nxt = S_MLO;
      end
      S_MLO: begin
        acc_nxt   = ACC_W'(mul_p);
        state_nxt = S_MHI;
      end
      S_MHI: begin
        acc_nxt   = acc_r + {mul_p, {RECIP_SPLIT{1'b0}}};
        state_nxt = S_REM;
      end
      S_REM: begin
        rem_nxt   = REM_BIAS - mul_p[REM_W-1:0];
        quot_nxt  = neg_r ? (SPEED_W'(0) - SPEED_W'(quot_est)) : SPEED_W'(quot_est);
        state_nxt = S_FIX;
      end
      S_FIX: begin
        held_speed_nxt = neg_r ? (quot_r - SPEED_W'(quot_fix))
                               : (quot_r + SPEED_W'(quot_fix));
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = tracked_angle_r;
          out_speed_nxt = held_speed_r;
          out_trans_nxt = trans_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      last_sector_r   <= '0;
      tracked_angle_r <= '0;
      angle_at_last_r <= '0;
      held_speed_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      last_sector_r   <= last_sector_nxt;
      tracked_angle_r <= tracked_angle_nxt;
      angle_at_last_r <= angle_at_last_nxt;
      held_speed_r    <= held_speed_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trans_r     <= trans_nxt;
    prod_r      <= prod_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    out_angle_r <= out_angle_nxt;
    out_speed_r <= out_speed_nxt;
    out_trans_r <= out_trans_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_angle_r <= SECTOR_RESET;
      step_angle_r   <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SECTOR_SIX, REG_SECTOR_FOUR, REG_SECTOR_FIVE,
        REG_SECTOR_ONE, REG_SECTOR_THREE, REG_SECTOR_TWO: begin
          sector_angle_r[cfg_index] <= cfg_data;
        end
        REG_STEP_ANGLE: begin
          step_angle_r <= cfg_data[STEP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_rotor_angle = signed'(out_angle_r);
  assign out_rotor_speed = signed'(out_speed_r);
  assign out_transition  = out_trans_r;

  `HERT_ASSERT_IMPLIES(a_rem_range, state_r == S_FIX, rem_r < REM_LIMIT, "remainder out of range")
  `HERT_ASSERT_NEXT(a_mlo_then_mhi, state_r == S_MLO, state_r == S_MHI, "multiply halves out of order")
  `HERT_ASSERT_NEXT(a_fix_emits, state_r == S_FIX, state_r == S_EMIT, "speed not handed over")
  `HERT_ASSERT_IMPLIES(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT, "word raised outside emit")

endmodule
`default_nettype wire
